// ===== rtl/bwid_pkg.sv =====
// Shared types and constants for the beacon WPS element detector.
// No dependencies; used by bwid_walker and beacon_wps_ie_detector_unit.
package bwid_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned BSSID_W     = 48;
    localparam int unsigned VIDX_W      = 3;

    localparam logic [POS_W-1:0] HDR_LEN     = 6'd24;
    localparam logic [POS_W-1:0] FIXED_LEN   = 6'd12;
    localparam logic [POS_W-1:0] WALK_START  = HDR_LEN + FIXED_LEN;
    localparam logic [POS_W-1:0] ADDR2_FIRST = 6'd10;
    localparam logic [POS_W-1:0] ADDR2_LAST  = 6'd15;

    localparam logic [BYTE_W-1:0] FC_MASK     = 8'hFC;
    localparam logic [BYTE_W-1:0] FC_BEACON   = 8'h80;
    localparam logic [BYTE_W-1:0] VENDOR_ID   = 8'd221;
    localparam logic [BYTE_W-1:0] MIN_WPS_LEN = 8'd4;
    localparam logic [VIDX_W-1:0] PREFIX_LEN  = 3'd4;

    typedef enum logic [1:0] {
        PH_ID    = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } elem_phase_t;

    typedef struct packed {
        logic              step;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } walk_ctl_t;

    function automatic logic [BYTE_W-1:0] wps_prefix_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] v;
        case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h50;
            2'd2:    v = 8'hF2;
            default: v = 8'h04;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/bwid_walker.sv =====
// Information element walker: tracks tag-length-value elements after the fixed fields.
// Depends on bwid_pkg.
module bwid_walker
(
    input  logic               clk,
    input  logic               rst_n,
    input  bwid_pkg::walk_ctl_t ctl,
    output logic               frame_wps
);

    bwid_pkg::elem_phase_t              phase_reg, phase_next;
    logic                               vendor_reg, vendor_next;
    logic [bwid_pkg::BYTE_W-1:0]        remain_reg, remain_next;
    logic [bwid_pkg::VIDX_W-1:0]        vidx_reg, vidx_next;
    logic                               prefix_reg, prefix_next;
    logic                               wps_reg, wps_next;
    logic                               stop_reg, stop_next;
    logic [bwid_pkg::BYTE_W-1:0]        remain_dec;
    logic                               prefix_upd;

    always_comb
    begin
        phase_next  = phase_reg;
        vendor_next = vendor_reg;
        remain_next = remain_reg;
        vidx_next   = vidx_reg;
        prefix_next = prefix_reg;
        wps_next    = wps_reg;
        stop_next   = stop_reg;
        remain_dec  = remain_reg - 8'd1;
        prefix_upd  = prefix_reg;

        if (ctl.step && !stop_reg)
        begin
            case (phase_reg)
                bwid_pkg::PH_ID:
                begin
                    vendor_next = (ctl.data == bwid_pkg::VENDOR_ID);
                    phase_next  = bwid_pkg::PH_LEN;
                end
                bwid_pkg::PH_LEN:
                begin
                    remain_next = ctl.data;
                    vidx_next   = '0;
                    prefix_next = vendor_reg && (ctl.data >= bwid_pkg::MIN_WPS_LEN);
                    phase_next  = (ctl.data == '0) ? bwid_pkg::PH_ID : bwid_pkg::PH_VALUE;
                end
                bwid_pkg::PH_VALUE:
                begin
                    if (vidx_reg < bwid_pkg::PREFIX_LEN)
                    begin
                        if (ctl.data != bwid_pkg::wps_prefix_byte(vidx_reg[1:0]))
                        begin
                            prefix_upd = 1'b0;
                        end
                        vidx_next = vidx_reg + 3'd1;
                    end
                    prefix_next = prefix_upd;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        if (prefix_upd)
                        begin
                            wps_next  = 1'b1;
                            stop_next = 1'b1;
                        end
                        phase_next = bwid_pkg::PH_ID;
                    end
                end
                default:
                begin
                    phase_next = bwid_pkg::PH_ID;
                end
            endcase
        end
    end

    assign frame_wps = wps_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bwid_pkg::PH_ID;
            vendor_reg <= 1'b0;
            remain_reg <= '0;
            vidx_reg   <= '0;
            prefix_reg <= 1'b0;
            wps_reg    <= 1'b0;
            stop_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            phase_reg  <= bwid_pkg::PH_ID;
            vendor_reg <= 1'b0;
            remain_reg <= '0;
            vidx_reg   <= '0;
            prefix_reg <= 1'b0;
            wps_reg    <= 1'b0;
            stop_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            vendor_reg <= vendor_next;
            remain_reg <= remain_next;
            vidx_reg   <= vidx_next;
            prefix_reg <= prefix_next;
            wps_reg    <= wps_next;
            stop_reg   <= stop_next;
        end
    end

endmodule

// ===== rtl/beacon_wps_ie_detector_unit.sv =====
// Top level of the beacon WPS detector: input register, header check, sticky flags, result register.
// Depends on bwid_pkg and bwid_walker.
//
// Each received byte is taken into an input register and processed from there by short compare
// and counter logic. One item can be accepted in every cycle unless the output register stalls.
// The result of a frame is loaded into the output register at the edge at which its last byte
// leaves the input register, so m_axis_tvalid rises once that byte has passed through the input
// and output registers and nothing waits. The only stall comes from the output register: a frame's
// last byte waits in the input register while an earlier result has not been taken. The BSSID is
// written through cfg_we and cfg_wdata while no frame is in flight; the user must keep to this.
module beacon_wps_ie_detector_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // frame_last
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] beacon_accepted, [1] beacon_seen, [2] wps_enabled
    input  logic        cfg_we,
    input  logic [47:0] cfg_wdata
);

    logic                          in_valid_reg;
    logic [bwid_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          in_last_reg;
    logic                          in_restart_reg;

    logic [bwid_pkg::BSSID_W-1:0]  bssid_reg;
    logic [bwid_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          hdr_reg, hdr_next;
    logic                          seen_reg, seen_next;
    logic                          wps_reg, wps_next;

    logic                          out_valid_reg;
    logic [2:0]                    out_data_reg;

    logic                          advance;
    logic                          seen_cur, wps_cur, accepted;
    logic [2:0]                    addr_idx;
    logic                          frame_wps;
    bwid_pkg::walk_ctl_t           walk_ctl;

    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign walk_ctl.step  = advance && (pos_reg >= bwid_pkg::WALK_START);
    assign walk_ctl.clear = advance && in_last_reg;
    assign walk_ctl.data  = in_byte_reg;

    bwid_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (walk_ctl),
        .frame_wps (frame_wps)
    );

    always_comb
    begin
        addr_idx = 3'(bwid_pkg::ADDR2_LAST - pos_reg);
        hdr_next = hdr_reg;
        if (pos_reg == '0)
        begin
            if ((in_byte_reg & bwid_pkg::FC_MASK) != bwid_pkg::FC_BEACON)
            begin
                hdr_next = 1'b0;
            end
        end
        else if (pos_reg >= bwid_pkg::ADDR2_FIRST && pos_reg <= bwid_pkg::ADDR2_LAST)
        begin
            if (in_byte_reg != bssid_reg[{addr_idx, 3'b000} +: 8])
            begin
                hdr_next = 1'b0;
            end
        end

        pos_next = (pos_reg >= bwid_pkg::WALK_START) ? pos_reg : pos_reg + 6'd1;

        seen_cur = in_restart_reg ? 1'b0 : seen_reg;
        wps_cur  = in_restart_reg ? 1'b0 : wps_reg;
        accepted = in_last_reg && !seen_cur && (pos_reg >= bwid_pkg::WALK_START - 6'd1)
                   && hdr_next;
        seen_next = accepted ? 1'b1 : seen_cur;
        wps_next  = accepted ? frame_wps : wps_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bssid_reg <= '0;
        end
        else if (cfg_we)
        begin
            bssid_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_last_reg    <= s_axis_tlast;
            in_restart_reg <= s_axis_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hdr_reg  <= 1'b1;
            seen_reg <= 1'b0;
            wps_reg  <= 1'b0;
        end
        else if (advance)
        begin
            seen_reg <= seen_next;
            wps_reg  <= wps_next;
            if (in_last_reg)
            begin
                pos_reg <= '0;
                hdr_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= pos_next;
                hdr_reg <= hdr_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= {seen_next && wps_next, seen_next, accepted};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_data_reg};

    // A reported WPS element always belongs to a beacon that has been taken.
    a_wps_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[2] || m_axis_tdata[1]))
        else $error("wps_enabled set without beacon_seen");

    // An accepted beacon is reported as seen in the same item.
    a_accept_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("beacon_accepted without beacon_seen");

    // The byte position saturates at the start of the element walk.
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= bwid_pkg::WALK_START)
        else $error("byte position beyond walk start");

    // A processed last byte always leaves a result in the output register.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> out_valid_reg)
        else $error("last byte processed without a result");

endmodule
